@@ rtl/bpa_pkg.sv @@
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants and helper functions for the bitmap page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

  localparam int unsigned ADDR_W     = 40;
  localparam int unsigned PAGE_SIZE  = 4096;
  localparam int unsigned MAX_PAGES  = 32768;
  localparam int unsigned WORD_BITS  = 64;

  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_SIZE);
  localparam int unsigned PG_W       = ADDR_W - PAGE_SHIFT;
  localparam int unsigned NWORDS     = (MAX_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned WIDX_W     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int unsigned BIT_W      = $clog2(WORD_BITS);
  localparam int unsigned CNT_W      = $clog2(MAX_PAGES + 1);
  localparam int unsigned PADDR_W    = 4;
  localparam int unsigned PDATA_W    = 64;

  localparam logic [1:0] REQ_INIT  = 2'd0;
  localparam logic [1:0] REQ_ALLOC = 2'd1;
  localparam logic [1:0] REQ_FREE  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NOMEM  = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  typedef logic [WORD_BITS-1:0] word_t;

  // Mask with bits [lim-1:0] set.
  function automatic word_t low_mask(logic [BIT_W:0] lim);
    word_t m;
    for (int b = 0; b < int'(WORD_BITS); b++) begin
      m[b] = ((BIT_W+1)'(b) < lim);
    end
    return m;
  endfunction

  // Number of managed pages in word w, clipped to 0..WORD_BITS.
  function automatic logic [BIT_W:0] word_limit(logic [CNT_W-1:0] n,
                                                logic [WIDX_W-1:0] w);
    logic [CNT_W+1:0] off;
    logic [CNT_W+1:0] rem;
    logic [BIT_W:0]   lim;
    off = (CNT_W+2)'({w, {BIT_W{1'b0}}});
    rem = {2'b00, n} - off;
    if (rem[CNT_W+1]) begin
      lim = '0;
    end else if (rem >= (CNT_W+2)'(WORD_BITS)) begin
      lim = (BIT_W+1)'(WORD_BITS);
    end else begin
      lim = rem[BIT_W:0];
    end
    return lim;
  endfunction

  // Index of the lowest set bit; v must be nonzero.
  function automatic logic [BIT_W-1:0] lowest_bit(word_t v);
    word_t           iso;
    logic [BIT_W-1:0] idx;
    iso = v & (~v + word_t'(1));
    for (int k = 0; k < int'(BIT_W); k++) begin
      idx[k] = 1'b0;
      for (int b = 0; b < int'(WORD_BITS); b++) begin
        if (((b >> k) & 1) == 1) begin
          idx[k] = idx[k] | iso[b];
        end
      end
    end
    return idx;
  endfunction

endpackage

@@ rtl/bpa_ram.sv @@
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module bpa_ram #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 512
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

@@ rtl/bitmap_page_allocator.sv @@
// ----------------------------------------------------------------------------
// bitmap_page_allocator
// First-fit physical page allocator over a used-bit bitmap held in RAM.
// ----------------------------------------------------------------------------
// After reset the block sweeps the bitmap RAM to all-used, one word per cycle,
// and holds busy high until the sweep is done. A request is taken when start
// is high and busy is low; its result appears for one cycle on done_o and
// cannot be stalled. Init writes every bitmap word, one per cycle. Alloc scans
// one word per cycle through the single RAM port, up to the word holding the
// first free page or the last managed word. Free is a read-modify-write of one
// word, and a rejected free writes nothing. An unknown request is rejected
// straight from idle, with no RAM access.
module bitmap_page_allocator
  import bpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         req_type_i,
  input  logic [ADDR_W-1:0]  free_address_i,
  output logic               done_o,
  output logic [1:0]         status_o,
  output logic [ADDR_W-1:0]  page_address_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam logic [2:0] S_CLEAR   = 3'd0;
  localparam logic [2:0] S_IDLE    = 3'd1;
  localparam logic [2:0] S_INIT    = 3'd2;
  localparam logic [2:0] S_SCAN    = 3'd3;
  localparam logic [2:0] S_FREE_CK = 3'd4;
  localparam logic [2:0] S_FREE_WR = 3'd5;

  // Configuration
  logic [ADDR_W-1:0] base_q, top_q;
  logic              cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;
  assign prdata = paddr[3] ? PDATA_W'(top_q) : PDATA_W'(base_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0;
      top_q  <= '0;
    end else if (cfg_we) begin
      if (paddr[3]) begin
        top_q <= pwdata[ADDR_W-1:0];
      end else begin
        base_q <= pwdata[ADDR_W-1:0];
      end
    end
  end

  // Page count from the registers as they stand
  logic [PG_W:0]   base_pg;
  logic [PG_W+1:0] span;
  logic [CNT_W-1:0] count;

  assign base_pg = {1'b0, base_q[ADDR_W-1:PAGE_SHIFT]}
                 + (PG_W+1)'(|base_q[PAGE_SHIFT-1:0]);
  assign span    = {2'b00, top_q[ADDR_W-1:PAGE_SHIFT]} - {1'b0, base_pg};

  always_comb begin
    if (span[PG_W+1] || span == '0) begin
      count = '0;
    end else if (span > (PG_W+2)'(MAX_PAGES)) begin
      count = CNT_W'(MAX_PAGES);
    end else begin
      count = span[CNT_W-1:0];
    end
  end

  // Control and request state
  logic [2:0]        state_q, state_d;
  logic [WIDX_W-1:0] word_q, word_d;
  logic [CNT_W-1:0]  n_q;
  logic [PG_W:0]     base_pg_q;
  logic [ADDR_W-1:0] addr_q;
  logic [BIT_W-1:0]  fbit_q, fbit_d;
  logic              done_q, done_d;
  logic [1:0]        status_q, status_d;
  logic [ADDR_W-1:0] paddr_q, paddr_d;
  logic              accept;

  // RAM port
  logic              ram_we;
  logic [WIDX_W-1:0] ram_addr;
  word_t             ram_wdata, ram_rdata;

  bpa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (NWORDS)
  ) u_bitmap (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // Word being scanned or initialized
  logic [BIT_W:0] lim;
  word_t          free_bits;
  logic           last_word;
  logic [BIT_W-1:0] hit_bit;
  logic [PG_W:0]  hit_pg;

  assign lim       = word_limit(n_q, word_q);
  assign free_bits = ~ram_rdata & low_mask(lim);
  assign last_word = (lim != (BIT_W+1)'(WORD_BITS)) || (word_q == WIDX_W'(NWORDS - 1));
  assign hit_bit   = lowest_bit(free_bits);
  assign hit_pg    = base_pg_q + (PG_W+1)'({word_q, hit_bit});

  // Free address check
  logic [PG_W+1:0] fpg;
  logic            free_bad;

  assign fpg      = {2'b00, addr_q[ADDR_W-1:PAGE_SHIFT]} - {1'b0, base_pg_q};
  assign free_bad = (addr_q[PAGE_SHIFT-1:0] != '0) || fpg[PG_W+1] || (fpg == '0)
                 || (fpg >= (PG_W+2)'(n_q));

  always_comb begin
    state_d   = state_q;
    word_d    = word_q;
    fbit_d    = fbit_q;
    done_d    = 1'b0;
    status_d  = status_q;
    paddr_d   = paddr_q;
    ram_we    = 1'b0;
    ram_addr  = word_q;
    ram_wdata = '1;
    unique case (state_q)
      S_CLEAR: begin
        ram_we = 1'b1;
        word_d = word_q + WIDX_W'(1);
        if (word_q == WIDX_W'(NWORDS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        word_d   = '0;
        ram_addr = '0;
        if (accept) begin
          status_d = ST_OK;
          paddr_d  = '0;
          unique case (req_type_i)
            REQ_INIT:  state_d = S_INIT;
            REQ_ALLOC: state_d = S_SCAN;
            REQ_FREE:  state_d = S_FREE_CK;
            default: begin
              status_d = ST_REJECT;
              done_d   = 1'b1;
            end
          endcase
        end
      end
      S_INIT: begin
        ram_we    = 1'b1;
        ram_wdata = ~low_mask(lim);
        if (word_q == '0) begin
          ram_wdata[0] = 1'b1;
        end
        word_d = word_q + WIDX_W'(1);
        if (word_q == WIDX_W'(NWORDS - 1)) begin
          state_d = S_IDLE;
          done_d  = 1'b1;
        end
      end
      S_SCAN: begin
        if (free_bits != '0) begin
          ram_we    = 1'b1;
          ram_wdata = ram_rdata | (word_t'(1) << hit_bit);
          paddr_d   = {hit_pg[PG_W-1:0], {PAGE_SHIFT{1'b0}}};
          state_d   = S_IDLE;
          done_d    = 1'b1;
        end else if (last_word) begin
          status_d = ST_NOMEM;
          state_d  = S_IDLE;
          done_d   = 1'b1;
        end else begin
          ram_addr = word_q + WIDX_W'(1);
          word_d   = word_q + WIDX_W'(1);
        end
      end
      S_FREE_CK: begin
        ram_addr = fpg[WIDX_W+BIT_W-1:BIT_W];
        word_d   = fpg[WIDX_W+BIT_W-1:BIT_W];
        fbit_d   = fpg[BIT_W-1:0];
        if (free_bad) begin
          status_d = ST_REJECT;
          state_d  = S_IDLE;
          done_d   = 1'b1;
        end else begin
          state_d = S_FREE_WR;
        end
      end
      S_FREE_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata & ~(word_t'(1) << fbit_q);
        state_d   = S_IDLE;
        done_d    = 1'b1;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      word_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      word_q  <= word_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fbit_q   <= fbit_d;
    status_q <= status_d;
    paddr_q  <= paddr_d;
    if (accept) begin
      n_q       <= count;
      base_pg_q <= base_pg;
      addr_q    <= free_address_i;
    end
  end

  assign done_o         = done_q;
  assign status_o       = status_q;
  assign page_address_o = paddr_q;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_done_single : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !accept |=> !done_o)
    else $error("result strobe repeated");

  a_addr_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && page_address_o != '0 |-> status_o == ST_OK)
    else $error("page address with failing status");

  a_clear_ones : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CLEAR |-> ram_we && ram_wdata == '1)
    else $error("clearing pass did not write all-used word");

  a_free_wr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FREE_WR |-> $past(state_q) == S_FREE_CK && !$past(free_bad))
    else $error("free write without a valid check");

endmodule

@@ verif/bitmap_page_allocator_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bitmap_page_allocator_tb
// Self-checking bench for the first-fit page allocator. Runs directed init,
// alloc, free and unknown requests over edge-case regions, then random phases with
// fresh region settings. Replies are checked against an in-bench bitmap.
// ----------------------------------------------------------------------------
module bitmap_page_allocator_tb;
  import bpa_pkg::*;

  localparam logic [1:0]         REQ_UNKNOWN   = 2'd3;
  localparam logic [PADDR_W-1:0] REG_BASE_ADDR = 4'h0;
  localparam logic [PADDR_W-1:0] REG_TOP_ADDR  = 4'h8;
  localparam int unsigned CLK_PERIOD    = 10;
  localparam int unsigned RESET_CYCLES  = 7;
  localparam int unsigned RAND_REQS     = 1170;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned TAIL_CYCLES   = 600;
  localparam int unsigned STALL_LIMIT   = 5000;
  localparam int unsigned MAX_REPORTS   = 10;

  typedef enum logic [1:0] {OP_REQ, OP_CFG, OP_DRAIN} op_kind_e;
  typedef enum logic [1:0] {DRV_FETCH, DRV_ACCESS, DRV_WRITE} drv_state_e;

  typedef struct {
    op_kind_e           kind;
    logic [1:0]         req;
    logic [ADDR_W-1:0]  data;
    logic [PADDR_W-1:0] reg_addr;
  } stim_op_t;

  typedef struct {
    logic [1:0]        status;
    logic [ADDR_W-1:0] page_address;
  } reply_t;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               start          = 1'b0;
  logic               busy;
  logic [1:0]         req_type_i     = REQ_INIT;
  logic [ADDR_W-1:0]  free_address_i = '0;
  logic               done_o;
  logic [1:0]         status_o;
  logic [ADDR_W-1:0]  page_address_o;
  logic               psel           = 1'b0;
  logic               penable        = 1'b0;
  logic               pwrite         = 1'b0;
  logic [PADDR_W-1:0] paddr          = '0;
  logic [PDATA_W-1:0] pwdata         = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  stim_op_t    request_q[$];
  reply_t      reply_q[$];
  int unsigned n_stim_reqs  = 0;
  int unsigned n_issued     = 0;
  int unsigned n_retired    = 0;
  int unsigned settle_cnt   = 0;
  int unsigned stall_cycles = 0;
  int unsigned mismatches   = 0;
  drv_state_e  drv_state    = DRV_FETCH;

  // bench copy of the allocator state
  logic [ADDR_W-1:0] pool_base = '0;
  logic [ADDR_W-1:0] pool_top  = '0;
  word_t             used_map [NWORDS];

  // region as queued by the stimulus, for address generation
  logic [ADDR_W-1:0] plan_base = '0;
  logic [ADDR_W-1:0] plan_top  = '0;

  bitmap_page_allocator i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .req_type_i     (req_type_i),
    .free_address_i (free_address_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .page_address_o (page_address_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic logic [63:0] rounded_base(logic [ADDR_W-1:0] b);
    logic [63:0] r;
    r = 64'(b);
    if (b[PAGE_SHIFT-1:0] != '0) begin
      r = r + 64'(PAGE_SIZE) - 64'(b[PAGE_SHIFT-1:0]);
    end
    return r;
  endfunction

  function automatic int unsigned managed_pages(logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] t);
    logic [63:0] rb;
    logic [63:0] n;
    rb = rounded_base(b);
    if (rb >= 64'(t)) begin
      return 0;
    end
    n = (64'(t) - rb) / 64'(PAGE_SIZE);
    return (n > 64'(MAX_PAGES)) ? MAX_PAGES : n[31:0];
  endfunction

  task automatic page_request(input logic [1:0] req, input logic [ADDR_W-1:0] addr,
                              output reply_t rep);
    int unsigned n;
    int unsigned lim;
    logic [63:0] rb;
    logic [63:0] pg;
    word_t       avail;
    bit          found;
    n = managed_pages(pool_base, pool_top);
    rb = rounded_base(pool_base);
    rep.status = ST_OK;
    rep.page_address = '0;
    found = 1'b0;
    case (req)
      REQ_INIT: begin
        foreach (used_map[i]) used_map[i] = '1;
        for (int unsigned p = 1; p < n; p++) begin
          used_map[p / WORD_BITS][p % WORD_BITS] = 1'b0;
        end
      end
      REQ_ALLOC: begin
        rep.status = ST_NOMEM;
        for (int unsigned w = 0; w < NWORDS && !found && w * WORD_BITS < n; w++) begin
          lim = n - w * WORD_BITS;
          avail = ~used_map[w];
          if (lim < WORD_BITS) begin
            avail = avail & ((word_t'(1) << lim) - word_t'(1));
          end
          if (avail != '0) begin
            for (int unsigned k = 0; k < WORD_BITS && !found; k++) begin
              if (avail[k]) begin
                used_map[w][k] = 1'b1;
                rep.page_address = ADDR_W'(rb + 64'(w * WORD_BITS + k) * 64'(PAGE_SIZE));
                rep.status = ST_OK;
                found = 1'b1;
              end
            end
          end
        end
      end
      REQ_FREE: begin
        if (addr[PAGE_SHIFT-1:0] != '0 || 64'(addr) < rb) begin
          rep.status = ST_REJECT;
        end else begin
          pg = (64'(addr) - rb) / 64'(PAGE_SIZE);
          if (pg == 0 || pg >= 64'(n)) begin
            rep.status = ST_REJECT;
          end else begin
            used_map[pg / WORD_BITS][pg % WORD_BITS] = 1'b0;
          end
        end
      end
      default: rep.status = ST_REJECT;
    endcase
  endtask

  task automatic queue_req(logic [1:0] req, logic [ADDR_W-1:0] a);
    request_q.push_back('{OP_REQ, req, a, '0});
    n_stim_reqs++;
  endtask

  task automatic queue_cfg(logic [ADDR_W-1:0] b, logic [ADDR_W-1:0] t);
    request_q.push_back('{OP_CFG, REQ_INIT, b, REG_BASE_ADDR});
    request_q.push_back('{OP_CFG, REQ_INIT, t, REG_TOP_ADDR});
    plan_base = b;
    plan_top  = t;
  endtask

  function automatic logic [ADDR_W-1:0] page_at(int unsigned idx);
    return ADDR_W'(rounded_base(plan_base) + 64'(idx) * 64'(PAGE_SIZE));
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return ADDR_W'({$urandom, $urandom});
  endfunction

  // Driver: start is held until the request is taken; APB writes only once idle.
  always @(posedge clk_i) begin : driver
    bit          start_nx;
    int unsigned issued_now;
    int unsigned idle_pct;
    stim_op_t    op;
    reply_t      rep;
    if (rst_ni) begin
      start_nx = start && busy;
      issued_now = n_issued;
      if (start && !busy) begin
        page_request(req_type_i, free_address_i, rep);
        reply_q.push_back(rep);
        issued_now++;
        n_issued <= issued_now;
      end
      case (drv_state)
        DRV_FETCH: if (!start_nx && request_q.size() != 0) begin
          op = request_q[0];
          if (op.kind == OP_REQ) begin
            settle_cnt <= 0;
            idle_pct = (issued_now < n_stim_reqs / 3) ? 9 :
                       (issued_now < 2 * n_stim_reqs / 3) ? 74 : 0;
            if ($urandom_range(99) >= idle_pct) begin
              op = request_q.pop_front();
              start_nx = 1'b1;
              req_type_i <= op.req;
              free_address_i <= op.data;
            end
          end else if (issued_now != n_retired || busy) begin
            settle_cnt <= 0;
          end else if (settle_cnt < SETTLE_CYCLES) begin
            settle_cnt <= settle_cnt + 1;
          end else begin
            settle_cnt <= 0;
            op = request_q.pop_front();
            if (op.kind == OP_CFG) begin
              psel <= 1'b1;
              penable <= 1'b0;
              pwrite <= 1'b1;
              paddr <= op.reg_addr;
              pwdata <= PDATA_W'(op.data);
              drv_state <= DRV_ACCESS;
            end
          end
        end
        DRV_ACCESS: begin
          penable <= 1'b1;
          drv_state <= DRV_WRITE;
        end
        DRV_WRITE: if (pready) begin
          if (paddr == REG_BASE_ADDR) begin
            pool_base = pwdata[ADDR_W-1:0];
          end else if (paddr == REG_TOP_ADDR) begin
            pool_top = pwdata[ADDR_W-1:0];
          end
          psel <= 1'b0;
          penable <= 1'b0;
          pwrite <= 1'b0;
          drv_state <= DRV_FETCH;
        end
        default: drv_state <= DRV_FETCH;
      endcase
      start <= start_nx;
    end
  end

  always @(posedge clk_i) begin : monitor
    reply_t want;
    if (rst_ni && done_o) begin
      if (n_retired == n_issued) begin
        if (mismatches < MAX_REPORTS) begin
          $display("unexpected reply: status %0d page %h", status_o, page_address_o);
        end
        mismatches++;
      end else begin
        want = reply_q.pop_front();
        if (status_o !== want.status || page_address_o !== want.page_address) begin
          if (mismatches < MAX_REPORTS) begin
            $display("reply %0d: status exp %0d got %0d, page exp %h got %h", n_retired,
                     want.status, status_o, want.page_address, page_address_o);
          end
          mismatches++;
        end
        n_retired <= n_retired + 1;
      end
    end
  end

  always @(posedge clk_i) begin : watchdog
    if ((start && !busy) || done_o || (psel && penable && pready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] t;
    int unsigned       n_rand;
    int unsigned       phase;
    int unsigned       len;
    int unsigned       cnt;
    int unsigned       sel;
    int unsigned       r;
    int unsigned       idx;
    foreach (used_map[i]) used_map[i] = '1;

    // reset state: empty region, every page used
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_FREE, '0);
    queue_req(REQ_UNKNOWN, '0);
    queue_req(REQ_INIT, '0);
    queue_req(REQ_ALLOC, '0);

    // misaligned base, six pages
    queue_cfg(40'h00_0000_1234, 40'h00_0000_8005);
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_INIT, '0);
    repeat (6) queue_req(REQ_ALLOC, '0);
    queue_req(REQ_FREE, page_at(2) | 40'h1);
    queue_req(REQ_FREE, 40'h00_0000_1000);
    queue_req(REQ_FREE, page_at(0));
    queue_req(REQ_FREE, page_at(6));
    queue_req(REQ_FREE, page_at(3));
    queue_req(REQ_FREE, page_at(3));
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_UNKNOWN, '1);
    queue_req(REQ_FREE, '1);

    // grow the region without a new init
    queue_cfg(40'h00_0000_1234, 40'h00_0000_C000);
    queue_req(REQ_ALLOC, '0);

    // empty regions: top below base, and a base that rounds past the top
    queue_cfg('1, '0);
    queue_req(REQ_INIT, '0);
    queue_req(REQ_ALLOC, '0);
    queue_cfg(40'hFF_FFFF_F001, '1);
    queue_req(REQ_FREE, 40'hFF_FFFF_F000);

    // whole address space, count saturates
    queue_cfg('0, '1);
    queue_req(REQ_INIT, '0);
    queue_req(REQ_ALLOC, '0);
    queue_req(REQ_FREE, page_at(MAX_PAGES));
    queue_req(REQ_FREE, page_at(MAX_PAGES - 1));

    n_rand = 0;
    phase = 0;
    while (n_rand < RAND_REQS) begin
      sel = $urandom_range(9);
      b = rand_addr();
      if ($urandom_range(1) == 1) begin
        b[PAGE_SHIFT-1:0] = '0;
      end
      if (sel == 0) begin
        t = b & rand_addr();
      end else if (sel == 1) begin
        b[39:30] = '0;
        t = ($urandom_range(1) == 1) ? '1 :
            ADDR_W'(64'(b) + 64'(MAX_PAGES + 1) * 64'(PAGE_SIZE) + 64'($urandom_range(0, 1 << 30)));
      end else begin
        if (&b[39:25]) begin
          b[25] = 1'b0;
        end
        cnt = (sel == 2) ? $urandom_range(1, 3) :
              (sel == 3) ? $urandom_range(WORD_BITS - 1, WORD_BITS + 2) : $urandom_range(1, 200);
        t = ADDR_W'(rounded_base(b) + 64'(cnt) * 64'(PAGE_SIZE) +
                    64'($urandom_range(0, PAGE_SIZE - 1)));
      end
      queue_cfg(b, t);
      cnt = managed_pages(b, t);
      queue_req(REQ_INIT, rand_addr());
      len = $urandom_range(60, 110);
      for (int unsigned j = 0; j < len; j++) begin
        r = $urandom_range(99);
        if (r < 45) begin
          queue_req(REQ_ALLOC, rand_addr());
        end else if (r < 85) begin
          if (cnt > 300) begin
            idx = ($urandom_range(9) == 0) ? $urandom_range(MAX_PAGES - 4, MAX_PAGES + 4) :
                  $urandom_range(0, 300);
          end else begin
            idx = $urandom_range(0, cnt + 1);
          end
          queue_req(REQ_FREE, page_at(idx));
        end else if (r < 90) begin
          queue_req(REQ_FREE, rand_addr());
        end else if (r < 94) begin
          queue_req(REQ_FREE, page_at($urandom_range(0, cnt)) |
                              ADDR_W'($urandom_range(1, PAGE_SIZE - 1)));
        end else if (r < 97) begin
          queue_req(REQ_UNKNOWN, rand_addr());
        end else begin
          queue_req(REQ_INIT, rand_addr());
        end
        // hold off new requests until every reply is back
        if (phase == 3 && j == len / 2) begin
          request_q.push_back('{OP_DRAIN, REQ_INIT, '0, '0});
        end
      end
      n_rand += len + 1;
      phase++;
    end

    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    do @(negedge clk_i);
    while (request_q.size() != 0 || drv_state != DRV_FETCH || start || n_issued != n_retired);
    repeat (TAIL_CYCLES) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
